// ===== sv/hashed_pattern_gen_check_top_macros.svh =====
// Assertion helpers for the pattern generator/checker.
// Both macros assume a clock named clk and a synchronous reset named rst in scope.
`ifndef HASHED_PATTERN_GEN_CHECK_TOP_MACROS_SVH
`define HASHED_PATTERN_GEN_CHECK_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

`define HPGC_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hpgc: same-cycle check failed");

`define HPGC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hpgc: next-cycle check failed");

`else

`define HPGC_ASSERT_NOW(lbl, ante, cons)
`define HPGC_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ===== sv/hpgc_pkg.sv =====
`default_nettype none

package hpgc_pkg;

  localparam int OFFSET_BITS = 32;
  localparam logic [OFFSET_BITS-1:0] OFFSET_MAX = '1;

  localparam logic [63:0] LCG_MULT = 64'h5851_F42D_4C95_7F2D;
  localparam logic [63:0] MIX_MULT = 64'hFF51_AFD7_ED55_8CCD;
  localparam int MIX_SHIFT = 33;

  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_BITS = $clog2(Q_DEPTH);

  typedef struct packed {
    logic       func;
    logic [7:0] data_byte;
    logic       last;
  } hpgc_in_t;

  typedef struct packed {
    logic [7:0]  pattern_byte;
    logic        byte_mismatch;
    logic        done_res;
    logic [31:0] first_bad_offset;
    logic        passed;
  } hpgc_out_t;

  // queue entry: one byte position, already numbered by the front end
  typedef struct packed {
    logic                   func;
    logic [7:0]             data_byte;
    logic                   last;
    logic [OFFSET_BITS-1:0] off;
    logic [OFFSET_BITS-1:0] count;
  } hpgc_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } hpgc_q_stat_t;

endpackage

`default_nettype wire

// ===== sv/hashed_pattern_gen_check_top.sv =====
// Position-keyed test pattern generator and checker.
// Input channel (item_valid/item_stall, payload item): one byte position per
// transaction, with func (0 generate, 1 check data_byte) and last.
// Output channel (res_valid/res_stall, payload res): one result per input
// transaction, in order: pattern byte, per-byte mismatch flag, and on the last
// byte the first bad offset (or byte count) and the pass flag.
// Config channel (cfg_valid/cfg_ready, cfg_data): writes pattern_seed; always
// ready, to be written only while the block is idle.
// A taken item passes the queue, the hash pipeline and the result register
// before it shows on res. Throughput: one item per cycle while the queue has
// room and res is not stalled; the hash runs as a five-stage pipeline behind
// a four-entry queue. Reset clears the seed, the offset, the mismatch record,
// the queue and the pipeline; no clearing pass is needed.
// When res_stall is held, the result register and hash pipeline freeze; the
// queue keeps filling and item_stall rises once its four entries are taken.
`default_nettype none

`include "hashed_pattern_gen_check_top_macros.svh"

module hashed_pattern_gen_check_top (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                item_valid,
  output logic                     item_stall,
  input  wire hpgc_pkg::hpgc_in_t  item,
  output logic                     res_valid,
  input  wire logic                res_stall,
  output hpgc_pkg::hpgc_out_t      res,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [31:0]         cfg_data
);

  logic [63:0]            seed_add;
  logic                   push;
  logic                   pop;
  hpgc_pkg::hpgc_item_t   push_item;
  hpgc_pkg::hpgc_item_t   head;
  hpgc_pkg::hpgc_q_stat_t q_stat;

  assign cfg_ready = 1'b1;

  // LCG multiplier folded into the seed so the offset product needs one add less
  always_ff @(posedge clk) begin
    if (rst) begin
      seed_add <= hpgc_pkg::LCG_MULT;
    end else if (cfg_valid && cfg_ready) begin
      seed_add <= hpgc_pkg::LCG_MULT + {32'b0, cfg_data};
    end
  end

  hpgc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_stall (item_stall),
    .q_stat     (q_stat),
    .push       (push),
    .push_item  (push_item)
  );

  hpgc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  hpgc_back u_back (
    .clk       (clk),
    .rst       (rst),
    .seed_add  (seed_add),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res       (res)
  );

  `HPGC_ASSERT_NOW(a_not_done_quiet, res_valid && !res.done_res, res.first_bad_offset == '0 && !res.passed)
  `HPGC_ASSERT_NOW(a_pass_clean, res_valid && res.passed, !res.byte_mismatch && res.done_res)
  `HPGC_ASSERT_NOW(a_no_pop_empty, pop, !q_stat.empty)
  `HPGC_ASSERT_NEXT(a_seed_load, cfg_valid && cfg_ready, seed_add == hpgc_pkg::LCG_MULT + {32'b0, $past(cfg_data)})

endmodule

`default_nettype wire

// ===== sv/hpgc_front.sv =====
`default_nettype none

module hpgc_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              item_valid,
  input  wire hpgc_pkg::hpgc_in_t item,
  output logic                   item_stall,
  input  wire hpgc_pkg::hpgc_q_stat_t q_stat,
  output logic                   push,
  output hpgc_pkg::hpgc_item_t   push_item
);

  logic [hpgc_pkg::OFFSET_BITS-1:0] offset;
  logic [hpgc_pkg::OFFSET_BITS-1:0] count;

  assign item_stall = q_stat.full;
  assign push       = item_valid && !q_stat.full;

  // count saturates along with the offset
  assign count = (offset == hpgc_pkg::OFFSET_MAX) ? hpgc_pkg::OFFSET_MAX
                                                  : offset + 1'b1;

  always_comb begin
    push_item.func      = item.func;
    push_item.data_byte = item.data_byte;
    push_item.last      = item.last;
    push_item.off       = offset;
    push_item.count     = count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      offset <= '0;
    end else if (push) begin
      offset <= item.last ? '0 : count;
    end
  end

endmodule

`default_nettype wire

// ===== sv/hpgc_queue.sv =====
`default_nettype none

module hpgc_queue (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire hpgc_pkg::hpgc_item_t push_item,
  input  wire logic                 pop,
  output hpgc_pkg::hpgc_item_t      head,
  output hpgc_pkg::hpgc_q_stat_t    q_stat
);

  hpgc_pkg::hpgc_item_t mem [hpgc_pkg::Q_DEPTH];

  logic [hpgc_pkg::Q_PTR_BITS-1:0] wr_ptr;
  logic [hpgc_pkg::Q_PTR_BITS-1:0] rd_ptr;
  logic [hpgc_pkg::Q_PTR_BITS:0]   fill;

  assign q_stat.full  = (fill == (hpgc_pkg::Q_PTR_BITS+1)'(hpgc_pkg::Q_DEPTH));
  assign q_stat.empty = (fill == '0);
  assign head         = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/hpgc_back.sv =====
`default_nettype none

module hpgc_back (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic [63:0]            seed_add,
  input  wire hpgc_pkg::hpgc_item_t   head,
  input  wire hpgc_pkg::hpgc_q_stat_t q_stat,
  output logic                        pop,
  output logic                        res_valid,
  input  wire logic                   res_stall,
  output hpgc_pkg::hpgc_out_t         res
);

  logic adv;

  // pipeline valids and item carried alongside the hash
  logic v1, v2, v3, v4, v5;
  hpgc_pkg::hpgc_item_t it1, it2, it3, it4, it5;

  // hash datapath registers
  logic [63:0] p0;
  logic [31:0] p1;
  logic [63:0] s2;
  logic [40:0] y3;
  logic [40:0] q0;
  logic [8:0]  q1;
  logic [8:0]  q2;
  logic [7:0]  pat5;

  // per-buffer record
  logic                             mismatch_seen;
  logic [hpgc_pkg::OFFSET_BITS-1:0] first_mismatch_at;

  logic [63:0] x3;
  logic [63:0] mix3;
  logic [63:0] q0_full;
  logic [8:0]  q1_full;
  logic [8:0]  q2_full;
  logic [40:0] z5;
  logic        bad;
  logic        seen_now;
  logic [hpgc_pkg::OFFSET_BITS-1:0] first_now;

  assign adv = !(res_valid && res_stall);
  assign pop = adv && !q_stat.empty;

  // (off+1)*L + seed == off*L + (L + seed); seed_add already holds L + seed
  assign x3   = s2 + seed_add;
  assign mix3 = x3 ^ (x3 >> hpgc_pkg::MIX_SHIFT);

  // only bits [40:0] of the second product feed the low output byte
  assign q0_full = y3[31:0] * hpgc_pkg::MIX_MULT[31:0];
  assign q1_full = y3[8:0] * hpgc_pkg::MIX_MULT[40:32];
  assign q2_full = y3[40:32] * hpgc_pkg::MIX_MULT[8:0];

  assign z5 = q0 + {q1 + q2, 32'b0};

  assign bad       = it5.func && (it5.data_byte != pat5);
  assign seen_now  = mismatch_seen || bad;
  assign first_now = mismatch_seen ? first_mismatch_at : it5.off;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1                <= 1'b0;
      v2                <= 1'b0;
      v3                <= 1'b0;
      v4                <= 1'b0;
      v5                <= 1'b0;
      res_valid         <= 1'b0;
      mismatch_seen     <= 1'b0;
      first_mismatch_at <= '0;
    end else if (adv) begin
      v1        <= !q_stat.empty;
      v2        <= v1;
      v3        <= v2;
      v4        <= v3;
      v5        <= v4;
      res_valid <= v5;
      if (v5) begin
        if (it5.last) begin
          mismatch_seen     <= 1'b0;
          first_mismatch_at <= '0;
        end else if (bad && !mismatch_seen) begin
          mismatch_seen     <= 1'b1;
          first_mismatch_at <= it5.off;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      it1 <= head;
      it2 <= it1;
      it3 <= it2;
      it4 <= it3;
      it5 <= it4;

      p0 <= head.off * hpgc_pkg::LCG_MULT[31:0];
      p1 <= head.off * hpgc_pkg::LCG_MULT[63:32];
      s2 <= p0 + {p1, 32'b0};
      y3 <= mix3[40:0];
      q0 <= q0_full[40:0];
      q1 <= q1_full;
      q2 <= q2_full;
      pat5 <= z5[7:0] ^ z5[40:33];

      res.pattern_byte     <= pat5;
      res.byte_mismatch    <= bad;
      res.done_res         <= it5.last;
      res.first_bad_offset <= it5.last ? (seen_now ? first_now : it5.count) : '0;
      res.passed           <= it5.last && !seen_now;
    end
  end

endmodule

`default_nettype wire

// ===== bench/tb_hashed_pattern_gen_check_top.sv =====
module tb_hashed_pattern_gen_check_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam bit FUNC_GEN = 1'b0;
  localparam bit FUNC_CHECK = 1'b1;
  localparam int RESULT_LATENCY = 6;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int PHASE_ITEMS = 230;

  typedef enum int {
    BUF_CLEAN,
    BUF_CORRUPT,
    BUF_GENERATE,
    BUF_MIXED,
    BUF_NOISE
  } buf_kind_t;

  // Tracks the pattern state per byte position and holds expected results.
  class pattern_scoreboard;
    bit [31:0] seed;
    bit [63:0] offset;
    bit        mismatch_seen;
    bit [63:0] first_bad_at;
    hpgc_pkg::hpgc_out_t expected_q[$];
    int        errors;

    function new();
      seed = '0;
      offset = '0;
      mismatch_seen = 1'b0;
      first_bad_at = '0;
      errors = 0;
    endfunction

    function bit [7:0] pattern_at(bit [63:0] off);
      bit [63:0] h;
      h = (off + 64'd1) * hpgc_pkg::LCG_MULT + {32'd0, seed};
      h ^= h >> hpgc_pkg::MIX_SHIFT;
      h = h * hpgc_pkg::MIX_MULT;
      h ^= h >> hpgc_pkg::MIX_SHIFT;
      return h[7:0];
    endfunction

    function bit [7:0] next_pattern();
      return pattern_at(offset & 64'(hpgc_pkg::OFFSET_MAX));
    endfunction

    function void note_item(hpgc_pkg::hpgc_in_t t);
      bit [63:0] lim;
      bit [63:0] off;
      bit [63:0] cnt;
      bit [63:0] rep;
      bit        bad;
      hpgc_pkg::hpgc_out_t r;
      lim = 64'(hpgc_pkg::OFFSET_MAX);
      off = offset & lim;
      r.pattern_byte = pattern_at(off);
      bad = (t.func == FUNC_CHECK) && (t.data_byte != r.pattern_byte);
      if (bad && !mismatch_seen) begin
        mismatch_seen = 1'b1;
        first_bad_at = off;
      end
      // offset counter saturates, and so does the reported count
      cnt = (off >= lim) ? lim : off + 64'd1;
      r.byte_mismatch = bad;
      r.done_res = t.last;
      r.first_bad_offset = '0;
      r.passed = 1'b0;
      if (t.last) begin
        rep = mismatch_seen ? first_bad_at : cnt;
        r.first_bad_offset = (rep > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : rep[31:0];
        r.passed = !mismatch_seen;
        offset = '0;
        mismatch_seen = 1'b0;
        first_bad_at = '0;
      end else begin
        offset = cnt;
      end
      expected_q.push_back(r);
    endfunction

    task report(string msg);
      if (errors < 40) $display("MISMATCH @%0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(hpgc_pkg::hpgc_out_t got);
      hpgc_pkg::hpgc_out_t want;
      if (expected_q.size() == 0) begin
        report("result with no transaction pending");
        return;
      end
      want = expected_q.pop_front();
      if (got.pattern_byte !== want.pattern_byte)
        report($sformatf("pattern_byte got %h want %h", got.pattern_byte, want.pattern_byte));
      if (got.byte_mismatch !== want.byte_mismatch)
        report($sformatf("byte_mismatch got %b want %b", got.byte_mismatch,
                         want.byte_mismatch));
      if (got.done_res !== want.done_res)
        report($sformatf("done_res got %b want %b", got.done_res, want.done_res));
      if (got.first_bad_offset !== want.first_bad_offset)
        report($sformatf("first_bad_offset got %0d want %0d", got.first_bad_offset,
                         want.first_bad_offset));
      if (got.passed !== want.passed)
        report($sformatf("passed got %b want %b", got.passed, want.passed));
    endtask
  endclass

  logic      clk = 1'b0;
  logic      rst;
  logic      item_valid;
  logic      item_stall;
  hpgc_pkg::hpgc_in_t  item;
  logic      res_valid;
  logic      res_stall = 1'b0;
  hpgc_pkg::hpgc_out_t res;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [31:0] cfg_data;

  pattern_scoreboard sb = new();

  int send_idle_pct;
  int res_stall_pct;
  int hold_cycles;
  int items_sent;
  int quiet_cycles;

  hashed_pattern_gen_check_top dut (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .item       (item),
    .res_valid  (res_valid),
    .res_stall  (res_stall),
    .res        (res),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // receiver: random stall, or a long hold-off when one is requested
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      res_stall <= 1'b1;
      hold_cycles--;
    end else begin
      res_stall <= ($urandom_range(99) < res_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (item_valid && !item_stall) sb.note_item(item);
      if (res_valid && !res_stall) sb.check_result(res);
      if (cfg_valid && cfg_ready) sb.seed = cfg_data;
    end
  end

  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (res_valid && !res_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // All driver tasks start and end at a falling edge.
  task automatic send_item(hpgc_pkg::hpgc_in_t t);
    while ($urandom_range(99) < send_idle_pct) begin
      item_valid <= 1'b0;
      @(negedge clk);
    end
    item_valid <= 1'b1;
    item <= t;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  task automatic send_buffer(int len, buf_kind_t kind, bit close);
    hpgc_pkg::hpgc_in_t t;
    bit [7:0] pat;
    for (int i = 0; i < len; i++) begin
      pat = sb.next_pattern();
      t.last = close && (i == len - 1);
      case (kind)
        BUF_CLEAN: begin
          t.func = FUNC_CHECK;
          t.data_byte = pat;
        end
        BUF_CORRUPT: begin
          t.func = FUNC_CHECK;
          t.data_byte = ($urandom_range(5) == 0) ? pat ^ (8'd1 << $urandom_range(7)) : pat;
        end
        BUF_GENERATE: begin
          t.func = FUNC_GEN;
          t.data_byte = 8'($urandom);
        end
        BUF_MIXED: begin
          t.func = 1'($urandom_range(1));
          t.data_byte = ($urandom_range(7) == 0) ? 8'($urandom) : pat;
        end
        default: begin
          t.func = 1'($urandom_range(1));
          t.data_byte = 8'($urandom);
        end
      endcase
      send_item(t);
    end
  endtask

  task automatic wait_drained();
    item_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (RESULT_LATENCY + 2) @(negedge clk);
  endtask

  task automatic write_seed(bit [31:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic run_phase(int send_pct, int stall_pct, bit pressure);
    int stop_at;
    int pick;
    buf_kind_t kind;
    bit [31:0] s;
    send_idle_pct = send_pct;
    res_stall_pct = stall_pct;
    stop_at = items_sent + PHASE_ITEMS;
    if (pressure) begin
      // hold the output long enough for the queue to fill and push back
      hold_cycles = HOLD_OFF_CYCLES;
      send_buffer(40, BUF_CLEAN, 1'b1);
      wait_drained();
    end
    while (items_sent < stop_at) begin
      if ($urandom_range(7) == 0) begin
        // sometimes leave a buffer open across the seed change
        if ($urandom_range(2) == 0) send_buffer($urandom_range(1, 6), BUF_CLEAN, 1'b0);
        wait_drained();
        case ($urandom_range(3))
          0: s = 32'h0000_0000;
          1: s = 32'hFFFF_FFFF;
          2: s = 32'd1 << $urandom_range(31);
          default: s = $urandom;
        endcase
        write_seed(s);
      end
      pick = $urandom_range(99);
      if (pick < 40) kind = BUF_CLEAN;
      else if (pick < 60) kind = BUF_CORRUPT;
      else if (pick < 75) kind = BUF_GENERATE;
      else if (pick < 90) kind = BUF_MIXED;
      else kind = BUF_NOISE;
      send_buffer(($urandom_range(9) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12),
                  kind, 1'b1);
    end
  endtask

  initial begin
    rst = 1'b1;
    item_valid = 1'b0;
    item = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    hold_cycles = 0;
    items_sent = 0;
    quiet_cycles = 0;
    send_idle_pct = 26;
    res_stall_pct = 48;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset seed, all bytes good
    send_buffer(4, BUF_CLEAN, 1'b1);
    // one generated byte as a whole buffer
    send_item('{func: FUNC_GEN, data_byte: 8'hFF, last: 1'b1});
    // bad byte at offset zero; buffer closed by a generate byte still fails
    send_item('{func: FUNC_CHECK, data_byte: sb.next_pattern() ^ 8'h80, last: 1'b0});
    send_item('{func: FUNC_CHECK, data_byte: 8'h00, last: 1'b0});
    send_item('{func: FUNC_CHECK, data_byte: 8'hFF, last: 1'b0});
    send_item('{func: FUNC_GEN, data_byte: 8'h00, last: 1'b1});
    // seed changed mid-buffer: offset carries over
    send_buffer(3, BUF_CLEAN, 1'b0);
    wait_drained();
    write_seed(32'hFFFF_FFFF);
    send_buffer(3, BUF_CLEAN, 1'b1);
    // only the last byte is wrong
    wait_drained();
    write_seed(32'h8000_0000);
    send_buffer(2, BUF_CLEAN, 1'b0);
    send_item('{func: FUNC_CHECK, data_byte: sb.next_pattern() ^ 8'h01, last: 1'b1});
    wait_drained();

    run_phase(26, 48, 1'b1);
    wait_drained();
    run_phase(48, 26, 1'b0);
    wait_drained();
    run_phase(0, 0, 1'b0);
    wait_drained();

    if (sb.expected_q.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.expected_q.size()));
    if (sb.errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
